### design/mhrl_pkg.sv
//------------------------------------------------------------------------------
// mhrl_pkg
// Shared types, codes and default sizes for the mode history ring lookup.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhrl_pkg;

  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int MODE_BITS_DEF     = 8;
  localparam int ITER_W            = 32;
  localparam int MODE_PORT_W       = 8;
  localparam int MODE_EXT_W        = 16;

  typedef enum logic [1:0] {
    CMD_UPDATE     = 2'd0,
    CMD_QUERY_CUR  = 2'd1,
    CMD_QUERY_NEXT = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOTFND  = 2'd1,
    ST_NO_NEXT = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]             cmd;
    logic                   new_state;
    logic [ITER_W-1:0]      iteration;
    logic [MODE_PORT_W-1:0] next_mode;
  } item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [MODE_PORT_W-1:0] mode_index;
    logic [ITER_W-1:0]      start_iteration;
    logic                   mode_state;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic exec_upd;
    logic exec_clr;
    logic walk;
    logic res_walk;
    logic res_next;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic miss;
    logic need_next;
  } dp_stat_t;

endpackage

### design/mhrl_ram.sv
//------------------------------------------------------------------------------
// mhrl_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/mhrl_ctrl.sv
//------------------------------------------------------------------------------
// mhrl_ctrl
// Sequencer: takes items, steps the newest-first record walk, picks the result.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhrl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         cmd,
  input  mhrl_pkg::dp_stat_t stat,
  output logic               busy,
  output mhrl_pkg::ctrl_cmd_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_NEXT = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.accept = 1'b1;
          if (cmd == mhrl_pkg::CMD_UPDATE) begin
            ctl.exec_upd = 1'b1;
          end else if (cmd == mhrl_pkg::CMD_CLEAR) begin
            ctl.exec_clr = 1'b1;
          end else begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        ctl.walk = 1'b1;
        if (stat.hit || stat.miss) begin
          // the follow-up read is issued in this same cycle
          if (stat.need_next) begin
            state_next = S_NEXT;
          end else begin
            ctl.res_walk = 1'b1;
            state_next   = S_IDLE;
          end
        end
      end
      S_NEXT: begin
        ctl.res_next = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

### design/mhrl_dp.sv
//------------------------------------------------------------------------------
// mhrl_dp
// Ring bookkeeping, record RAM, walk pointer, compare and result register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhrl_dp #(
  parameter int HISTORY_DEPTH = mhrl_pkg::HISTORY_DEPTH_DEF,
  parameter int MODE_BITS     = mhrl_pkg::MODE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  mhrl_pkg::item_t     item,
  input  mhrl_pkg::ctrl_cmd_t ctl,
  output mhrl_pkg::dp_stat_t  stat,
  output logic                done,
  output mhrl_pkg::result_t   result
);

  localparam int PW    = $clog2(HISTORY_DEPTH);
  localparam int CW    = $clog2(HISTORY_DEPTH + 1);
  localparam int REC_W = mhrl_pkg::ITER_W + MODE_BITS;

  logic [PW-1:0]        oldest, newest;
  logic [CW-1:0]        count;
  logic [MODE_BITS-1:0] cur_mode;
  logic                 flag;

  // walk state
  logic [1:0]                  cmd_q;
  logic [mhrl_pkg::ITER_W-1:0] it_q;
  logic [PW-1:0]               ptr, pend_slot;
  logic [CW-1:0]               left;
  logic                        pend;

  // RAM
  logic                 we;
  logic [PW-1:0]        waddr, raddr;
  logic [REC_W-1:0]     wdata, rdata;
  logic [MODE_BITS-1:0] rd_mode;
  logic [mhrl_pkg::ITER_W-1:0] rd_iter;

  // update decode
  logic [mhrl_pkg::MODE_EXT_W-1:0] nm_ext, res_mode_ext;
  logic [MODE_BITS-1:0]            nmode, res_mode;
  logic                            completes, full;
  logic [PW-1:0]                   newest_inc, oldest_inc, pend_inc, ptr_dec, nx_slot;

  // result staging
  logic [1:0]                  res_status;
  logic [mhrl_pkg::ITER_W-1:0] res_start;
  logic                        res_state, res_load;

  mhrl_ram #(
    .WIDTH(REC_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_mode = rdata[MODE_BITS-1:0];
  assign rd_iter = rdata[REC_W-1:MODE_BITS];

  assign nm_ext = mhrl_pkg::MODE_EXT_W'(item.next_mode);
  assign nmode  = nm_ext[MODE_BITS-1:0];

  assign newest_inc = (newest == PW'(HISTORY_DEPTH - 1)) ? '0 : newest + 1'b1;
  assign oldest_inc = (oldest == PW'(HISTORY_DEPTH - 1)) ? '0 : oldest + 1'b1;
  assign pend_inc   = (pend_slot == PW'(HISTORY_DEPTH - 1)) ? '0 : pend_slot + 1'b1;
  assign ptr_dec    = (ptr == '0) ? PW'(HISTORY_DEPTH - 1) : ptr - 1'b1;
  assign full       = (count == CW'(HISTORY_DEPTH));

  assign completes = !flag && item.new_state &&
                     ((cur_mode != nmode) || (item.iteration == '0));

  assign we    = ctl.exec_upd && completes;
  assign waddr = newest_inc;
  assign wdata = {item.iteration, nmode};

  // compare the record read in the previous cycle
  assign stat.hit  = pend && (rd_iter <= it_q);
  assign stat.miss = !pend && (left == '0);
  assign stat.need_next = (cmd_q == mhrl_pkg::CMD_QUERY_NEXT) &&
                          ((stat.hit && (pend_slot != newest)) ||
                           (stat.miss && (it_q == '0) && (count != '0)));

  assign nx_slot = stat.hit ? pend_inc : oldest;
  assign raddr   = (stat.hit || stat.miss) ? nx_slot : ptr;

  // ring bookkeeping
  always_ff @(posedge clk) begin
    if (rst || ctl.exec_clr) begin
      oldest   <= '0;
      newest   <= PW'(HISTORY_DEPTH - 1);
      count    <= '0;
      cur_mode <= '0;
      flag     <= 1'b0;
    end else if (ctl.exec_upd) begin
      flag <= item.new_state;
      if (completes) begin
        cur_mode <= nmode;
        newest   <= newest_inc;
        if (full) begin
          oldest <= oldest_inc;
        end else begin
          count <= count + 1'b1;
        end
      end
    end
  end

  // walk, newest record first, one read per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      left <= '0;
    end else if (ctl.accept) begin
      pend <= 1'b0;
      left <= count;
    end else if (ctl.walk) begin
      if (left != '0) begin
        left <= left - 1'b1;
        pend <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_q <= item.cmd;
      it_q  <= item.iteration;
      ptr   <= newest;
    end else if (ctl.walk && (left != '0)) begin
      ptr       <= ptr_dec;
      pend_slot <= ptr;
    end
  end

  always_comb begin
    res_status = mhrl_pkg::ST_OK;
    res_mode   = '0;
    res_start  = '0;
    res_state  = flag;
    if (ctl.exec_upd) begin
      res_mode  = completes ? nmode : cur_mode;
      res_state = item.new_state;
    end else if (ctl.exec_clr) begin
      res_state = 1'b0;
    end else if (ctl.res_next) begin
      res_mode  = rd_mode;
      res_start = rd_iter;
    end else if (ctl.res_walk) begin
      if (cmd_q == mhrl_pkg::CMD_QUERY_CUR) begin
        if (stat.hit) begin
          res_mode = rd_mode;
        end else if (it_q != '0) begin
          res_status = mhrl_pkg::ST_NOTFND;
        end
      end else if (stat.miss && (it_q != '0)) begin
        res_status = mhrl_pkg::ST_NOTFND;
      end else begin
        res_status = mhrl_pkg::ST_NO_NEXT;
      end
    end
  end

  assign res_load     = ctl.exec_upd || ctl.exec_clr || ctl.res_walk || ctl.res_next;
  assign res_mode_ext = mhrl_pkg::MODE_EXT_W'(res_mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.status          <= res_status;
      result.mode_index      <= res_mode_ext[mhrl_pkg::MODE_PORT_W-1:0];
      result.start_iteration <= res_start;
      result.mode_state      <= res_state;
    end
  end

endmodule

### design/mode_history_ring_lookup_top.sv
//------------------------------------------------------------------------------
// mode_history_ring_lookup_top
// Ring of recent (iteration, mode) transition records with mode queries.
//------------------------------------------------------------------------------
// Update and clear: result strobe in the cycle after accept; one item per cycle while not busy.
// Queries: up to N valid records are read newest first through the one RAM
//   read port, one per cycle; a next-mode query may then read one more
//   record before its result.
// Reset clears mode, state flag and ring pointers; record RAM is not cleared.
// Results show for one cycle on done; the receiver cannot stall.
`timescale 1ns / 1ps

module mode_history_ring_lookup_top #(
  parameter int HISTORY_DEPTH = mhrl_pkg::HISTORY_DEPTH_DEF,
  parameter int MODE_BITS     = mhrl_pkg::MODE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mhrl_pkg::item_t   item,
  output logic              done,
  output mhrl_pkg::result_t result
);

  mhrl_pkg::ctrl_cmd_t ctl;
  mhrl_pkg::dp_stat_t  stat;

  mhrl_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (item.cmd),
    .stat (stat),
    .busy (busy),
    .ctl  (ctl)
  );

  mhrl_dp #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .MODE_BITS    (MODE_BITS)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .ctl   (ctl),
    .stat  (stat),
    .done  (done),
    .result(result)
  );

endmodule
